// ===== sv/itrd_pkg.sv =====
package itrd_pkg;

  // Field widths of the transactions
  localparam int VALUE_BITS = 32;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 6;

  // Magnitude of a positive value and the divider's bit counter
  localparam int MAG_W      = VALUE_BITS - 1;
  localparam int BITCNT_W   = $clog2(MAG_W + 1);

  // Quotient bits resolved per cycle by the shared divider
  localparam int DIV_STEP   = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(36);
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A    = 8'h41;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]           radix;
  } itrd_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic              bad_radix;
  } itrd_out_t;

  // Map a digit 0..35 to '0'..'9', 'A'..'Z'
  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DEC_DIGITS) begin
      ch = ASCII_ZERO + CHAR_W'(d);
    end else begin
      ch = ASCII_A + CHAR_W'(d - DEC_DIGITS);
    end
    return ch;
  endfunction

endpackage

// ===== sv/integer_to_radix_digits.sv =====
// Converts a signed integer to its digit characters in a base from 2 to 36.
// Input channel in_valid/in_stall/in_data carries the value and the radix;
// output channel out_valid/out_stall/out_data carries one character per
// transaction, most significant digit first, with last set on the final one.
// A zero or negative value gives the single character '0'. A radix outside
// 2..36 gives one character '0' with bad_radix and last set.
// One item is worked on at a time: in_stall stays high from acceptance
// until the last character has been loaded into the output register.
// Each digit is one division by the radix on a shared restoring divider
// that resolves 4 quotient bits per cycle. Characters are then read back
// from the digit store, each by a store read followed by an output load.
// A stall on the output holds the output register and pauses emission;
// the divider never waits on the output.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the output register; the digit store needs no clearing.
module integer_to_radix_digits #(
  parameter int MAX_DIGITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  itrd_pkg::itrd_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output itrd_pkg::itrd_out_t out_data
);
  import itrd_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIGITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_SEND = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [MAG_W-1:0]     quo_r, quo_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [BITCNT_W-1:0]  bits_r, bits_nxt;
  logic [RADIX_W-1:0]   radix_r, radix_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 bad_r, bad_nxt;
  logic                 out_valid_r, out_valid_nxt;
  itrd_out_t            out_r, out_nxt;

  logic [DIGIT_W-1:0]   digit_store [MAX_DIGITS];
  logic [DIGIT_W-1:0]   rd_data_r;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [DIGIT_W-1:0]   wr_data;
  logic                 rd_en;

  logic                 in_acc;
  logic                 radix_bad;
  logic                 value_nonpos;
  logic                 out_free;
  logic [MAG_W-1:0]     div_quo;
  logic [DIGIT_W-1:0]   div_rem;
  logic                 div_done;

  assign in_stall     = (state_r != S_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign radix_bad    = (in_data.radix < RADIX_MIN) || (in_data.radix > RADIX_MAX);
  assign value_nonpos = in_data.value[VALUE_BITS-1] || (in_data.value == '0);
  assign out_free     = !out_valid_r || !out_stall;
  assign div_done     = (bits_r <= BITCNT_W'(DIV_STEP));

  // Shared divider: resolve up to DIV_STEP quotient bits per cycle
  always_comb begin
    logic [DIGIT_W:0] sh;
    div_quo = quo_r;
    div_rem = rem_r;
    sh      = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      if (BITCNT_W'(k) < bits_r) begin
        sh      = {div_rem, div_quo[MAG_W-1]};
        div_quo = {div_quo[MAG_W-2:0], 1'b0};
        if (sh >= {1'b0, radix_r}) begin
          sh         = sh - {1'b0, radix_r};
          div_quo[0] = 1'b1;
        end
        div_rem = sh[DIGIT_W-1:0];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bits_nxt      = bits_r;
    radix_nxt     = radix_r;
    idx_nxt       = idx_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_idx        = idx_r;
    wr_data       = div_rem;
    rd_en         = 1'b0;

    // Drop the output transaction once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          radix_nxt = in_data.radix;
          idx_nxt   = '0;
          bad_nxt   = 1'b0;
          if (radix_bad) begin
            bad_nxt   = 1'b1;
            state_nxt = S_SEND;
          end else if (value_nonpos) begin
            wr_en     = 1'b1;
            wr_idx    = '0;
            wr_data   = '0;
            state_nxt = S_READ;
          end else begin
            quo_nxt   = in_data.value[MAG_W-1:0];
            rem_nxt   = '0;
            bits_nxt  = BITCNT_W'(MAG_W);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        quo_nxt  = div_quo;
        rem_nxt  = div_rem;
        bits_nxt = bits_r - BITCNT_W'(DIV_STEP);
        if (div_done) begin
          // Store the remainder; restart on the quotient or start emitting
          wr_en  = 1'b1;
          wr_idx = idx_r;
          if ((div_quo == '0) || (idx_r == IDX_W'(MAX_DIGITS - 1))) begin
            state_nxt = S_READ;
          end else begin
            idx_nxt  = idx_r + IDX_W'(1);
            rem_nxt  = '0;
            bits_nxt = BITCNT_W'(MAG_W);
          end
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt.bad_radix = bad_r;
          out_nxt.char_code = bad_r ? ASCII_ZERO : ascii_of(rd_data_r);
          out_nxt.last      = bad_r || (idx_r == '0);
          if (bad_r || (idx_r == '0)) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bad_r       <= 1'b0;
      idx_r       <= '0;
      bits_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bad_r       <= bad_nxt;
      idx_r       <= idx_nxt;
      bits_r      <= bits_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
    out_r   <= out_nxt;
  end

  // Digit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_store[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= digit_store[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A bad radix always closes its number in one character
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_radix |-> out_data.last)
    else $error("bad_radix character without last");

  // Running remainder stays below the radix during division
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < radix_r)
    else $error("remainder not below radix");

  // A rejected radix goes straight to the single error character
  a_bad_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && radix_bad |=> (state_r == S_SEND) && bad_r)
    else $error("bad radix did not take the error path");

  // Division only runs with a valid radix
  a_div_radix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (radix_r >= RADIX_MIN) && (radix_r <= RADIX_MAX) && !bad_r)
    else $error("division with an invalid radix");

endmodule
